@@ src/fir_convolution_16bit_unit_macros.svh @@
// Assertion macros for the FIR convolution unit.
// Uses the clock and reset names of the including module; needs no other file.
`ifndef FIR_CONVOLUTION_16BIT_UNIT_MACROS_SVH
`define FIR_CONVOLUTION_16BIT_UNIT_MACROS_SVH

// Condition in this cycle implies expression in the next cycle.
`define FIR16_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("fir16 assertion failed");

// Condition implies expression in the same cycle.
`define FIR16_ASSERT_NOW(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("fir16 assertion failed");

`endif

@@ src/fir16_pkg.sv @@
// Shared constants, item codes, wave type and product scaling for the FIR unit.
// No dependencies.
package fir16_pkg;

   localparam int MAX_TAPS       = 64;
   localparam int TAP_IDX_W      = 6;
   localparam int TAP_COUNT_W    = 7;
   localparam int COEF_FRAC_BITS = 14;
   localparam int SAMPLE_W       = 16;
   localparam int COEF_W         = 18;
   localparam int PROD_W         = SAMPLE_W + COEF_W;
   localparam int SCALED_W       = PROD_W + 1 - COEF_FRAC_BITS;

   localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = TAP_COUNT_W'(MAX_TAPS);

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // One item as it travels down the cell chain.
   typedef struct packed {
      logic                       valid;
      logic                       cmd;
      logic [TAP_IDX_W-1:0]       tap_index;
      logic signed [COEF_W-1:0]   tap_value;
      logic signed [SAMPLE_W-1:0] carry;     // sample being shifted into the next cell
      logic [SAMPLE_W-1:0]        acc;       // wrapping partial sum
      logic signed [PROD_W-1:0]   prod;      // raw product of the previous cell
      logic                       prod_act;  // previous cell is an active tap
   } wave_type;

   // Scale a product down with truncation toward zero, then saturate to 16 bits.
   function automatic logic signed [SAMPLE_W-1:0] scale_sat(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W:0]   biased;
      logic signed [SCALED_W-1:0] q;
      logic                     all_ones;
      logic                     all_zeros;
      logic signed [SAMPLE_W-1:0] r;
      if (p[PROD_W-1]) begin
         biased = {p[PROD_W-1], p} + (PROD_W+1)'((1 << COEF_FRAC_BITS) - 1);
      end else begin
         biased = {p[PROD_W-1], p};
      end
      q         = biased[PROD_W:COEF_FRAC_BITS];
      all_ones  = &q[SCALED_W-1:SAMPLE_W-1];
      all_zeros = ~|q[SCALED_W-1:SAMPLE_W-1];
      if (q[SCALED_W-1] && !all_ones) begin
         r = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else if (!q[SCALED_W-1] && !all_zeros) begin
         r = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else begin
         r = q[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ src/fir_convolution_16bit_unit.sv @@
// FIR convolution unit: systolic chain of 64 tap cells plus an output register.
// An accepted sample item passes through every cell register and then the output register.
// Throughput: one item per cycle while no result stalls; each item moves one cell per cycle down the chain.
// A stalled result freezes the whole chain until it is taken.
// Reset (synchronous, active high) clears delay line, coefficients, tap_count to 64.
// Depends on fir16_pkg, fir16_cell and fir_convolution_16bit_unit_macros.svh.
`include "fir_convolution_16bit_unit_macros.svh"

module fir_convolution_16bit_unit (
   input  logic        clock,
   input  logic        reset,
   // input item channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // tap_index[5:0], tap_value[23:6], sample_in[39:24]
   input  logic        req_tuser,   // command: 0 load coefficient, 1 feed sample
   // result item channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // sample_out[15:0]
   // tap count register
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data  // tap_count[6:0]
);

   localparam int N = fir16_pkg::MAX_TAPS;

   logic [fir16_pkg::TAP_COUNT_W-1:0] tap_count_ff, tap_count_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [fir16_pkg::SAMPLE_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                              advance;
   fir16_pkg::wave_type               chain [0:N];
   fir16_pkg::wave_type               tail;
   logic [fir16_pkg::SAMPLE_W-1:0]    tail_addend;
   logic [fir16_pkg::SAMPLE_W-1:0]    tail_sum;
   logic                              tail_result;

   // Advance the chain whenever the output register is free or being emptied.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   // Build the head wave straight from the input item.
   always_comb begin
      chain[0].valid     = req_tvalid;
      chain[0].cmd       = req_tuser;
      chain[0].tap_index = req_tdata[5:0];
      chain[0].tap_value = req_tdata[23:6];
      chain[0].carry     = req_tdata[39:24];
      chain[0].acc       = '0;
      chain[0].prod      = '0;
      chain[0].prod_act  = 1'b0;
   end

   // One cell per tap; cell g holds delay_line[g] and coefficient g.
   for (genvar g = 0; g < N; g++) begin : g_cell
      fir16_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .cell_id   (fir16_pkg::TAP_IDX_W'(g)),
         .tap_count (tap_count_ff),
         .wave_in   (chain[g]),
         .wave_out  (chain[g+1])
      );
   end

   // Fold in the last cell's product and capture sample results.
   assign tail        = chain[N];
   assign tail_addend = (tail.valid && tail.prod_act) ?
                        $unsigned(fir16_pkg::scale_sat(tail.prod)) : '0;
   assign tail_sum    = tail.acc + tail_addend;
   assign tail_result = tail.valid && tail.cmd == fir16_pkg::CMD_SAMPLE;

   always_comb begin
      tap_count_in = tap_count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (csr_wr_en) begin
         tap_count_in = csr_wr_data;
      end
      if (advance) begin
         rsp_valid_in = tail_result;
         if (tail_result) begin
            rsp_data_in = tail_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= fir16_pkg::TAP_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         tap_count_ff <= tap_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A sample leaving the chain always shows up as a result.
   `FIR16_ASSERT_NEXT(a_sample_gives_result, advance && tail_result, rsp_valid_ff)
   // A load or a bubble leaving the chain never shows up as a result.
   `FIR16_ASSERT_NEXT(a_load_gives_none, advance && !tail_result, !rsp_valid_ff)
   // The chain only stops while a result is pending, and that result stays.
   `FIR16_ASSERT_NEXT(a_stall_holds_result, !advance, rsp_valid_ff)

endmodule

@@ src/fir16_cell.sv @@
// One tap cell of the FIR chain: holds one delay sample and one coefficient.
// Depends on fir16_pkg.
module fir16_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic [fir16_pkg::TAP_IDX_W-1:0]     cell_id,
   input  logic [fir16_pkg::TAP_COUNT_W-1:0]   tap_count,
   input  fir16_pkg::wave_type                 wave_in,
   output fir16_pkg::wave_type                 wave_out
);

   logic signed [fir16_pkg::SAMPLE_W-1:0] d_ff, d_in;
   logic signed [fir16_pkg::COEF_W-1:0]   c_ff, c_in;
   fir16_pkg::wave_type                   wave_ff, wave_in_nx;
   logic                                  active;
   logic [fir16_pkg::SAMPLE_W-1:0]        addend;

   assign active = tap_count > {1'b0, cell_id};

   always_comb begin
      d_in       = d_ff;
      c_in       = c_ff;
      wave_in_nx = wave_ff;
      addend     = '0;
      if (wave_in.valid && wave_in.prod_act) begin
         addend = $unsigned(fir16_pkg::scale_sat(wave_in.prod));
      end
      if (advance) begin
         wave_in_nx          = wave_in;
         wave_in_nx.acc      = wave_in.acc + addend;
         wave_in_nx.prod_act = 1'b0;
         if (wave_in.valid && wave_in.cmd == fir16_pkg::CMD_SAMPLE) begin
            // shift: take the upstream sample, hand ours downstream
            d_in                = wave_in.carry;
            wave_in_nx.carry    = d_ff;
            wave_in_nx.prod     = wave_in.carry * c_ff;
            wave_in_nx.prod_act = active;
         end
         if (wave_in.valid && wave_in.cmd == fir16_pkg::CMD_LOAD
             && wave_in.tap_index == cell_id) begin
            c_in = wave_in.tap_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      wave_ff.cmd       <= wave_in_nx.cmd;
      wave_ff.tap_index <= wave_in_nx.tap_index;
      wave_ff.tap_value <= wave_in_nx.tap_value;
      wave_ff.carry     <= wave_in_nx.carry;
      wave_ff.acc       <= wave_in_nx.acc;
      wave_ff.prod      <= wave_in_nx.prod;
      wave_ff.prod_act  <= wave_in_nx.prod_act;
      if (reset) begin
         d_ff          <= '0;
         c_ff          <= '0;
         wave_ff.valid <= 1'b0;
      end else begin
         d_ff          <= d_in;
         c_ff          <= c_in;
         wave_ff.valid <= wave_in_nx.valid;
      end
   end

   assign wave_out = wave_ff;

endmodule

@@ tb/sv/tb_fir_convolution_16bit_unit.sv @@
// Self-checking testbench for fir_convolution_16bit_unit: coefficient loads, sample feeds,
// tap count settings, random stream stalls on both channels, outputs checked in order.
// Depends on fir16_pkg and the unit itself.
module tb_fir_convolution_16bit_unit;
   import fir16_pkg::*;

   // Chain depth plus margin; used when letting loads drain out
   localparam int CHAIN_LATENCY = 80;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASE_ITEMS   = 153;
   localparam logic signed [COEF_W-1:0]   COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic signed [COEF_W-1:0]   COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // tap_index[5:0], tap_value[23:6], sample_in[39:24]
   logic        req_tuser;   // command: 0 load coefficient, 1 feed sample
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // sample_out[15:0]
   logic        csr_wr_en;
   logic [6:0]  csr_wr_data; // tap_count[6:0]

   // Filter state as the block should hold it
   logic signed [SAMPLE_W-1:0] history [MAX_TAPS];
   logic signed [COEF_W-1:0]   coefs [MAX_TAPS];
   logic [TAP_COUNT_W-1:0]     taps_in_use;

   logic [SAMPLE_W-1:0] expected_outputs [$];

   logic req_taken;
   logic burst_mode;
   int   error_count;
   int   items_sent;
   int   loads_sent;
   int   outputs_checked;
   int   cycle_count;

   fir_convolution_16bit_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // One tap: scale the product down toward zero, clamp to 16 bits, keep the raw bits
   function automatic logic [SAMPLE_W-1:0] scaled_tap(input logic signed [SAMPLE_W-1:0] x,
                                                       input logic signed [COEF_W-1:0] h);
      longint prod;
      longint mag;
      longint q;
      prod = longint'(x) * longint'(h);
      mag  = (prod < 0) ? -prod : prod;
      q    = mag >> COEF_FRAC_BITS;
      if (prod < 0) begin
         q = -q;
      end
      if (q > 32767) begin
         q = 32767;
      end else if (q < -32768) begin
         q = -32768;
      end
      return q[SAMPLE_W-1:0];
   endfunction

   // Shift a sample into the history and sum the active taps with 16-bit wraparound
   function automatic logic [SAMPLE_W-1:0] filter_sample(input logic signed [SAMPLE_W-1:0] s);
      logic [SAMPLE_W-1:0] acc;
      int                  active;
      for (int j = MAX_TAPS - 1; j > 0; j--) begin
         history[j] = history[j-1];
      end
      history[0] = s;
      active = (taps_in_use > MAX_TAPS) ? MAX_TAPS : int'(taps_in_use);
      acc = '0;
      for (int j = 0; j < active; j++) begin
         acc = acc + scaled_tap(history[j], coefs[j]);
      end
      return acc;
   endfunction

   // Capture input handshakes; the send task reads this at the following falling edge
   always @(posedge clock) begin
      req_taken <= !reset && req_tvalid && req_tready;
   end

   // Stall the result channel about 9 percent of the time, never in burst mode
   always @(negedge clock) begin
      rsp_tready = burst_mode || ($urandom_range(99) >= 9);
   end

   // Compare every accepted result against the oldest pending expectation
   always @(posedge clock) begin : check_outputs
      logic [SAMPLE_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_outputs.size() == 0) begin
            $error("sample_out: result item with nothing expected, actual %0d",
                   $signed(rsp_tdata));
            error_count++;
         end else begin
            want = expected_outputs.pop_front();
            outputs_checked++;
            if (rsp_tdata !== want) begin
               $error("sample_out mismatch: expected %0d, actual %0d",
                      $signed(want), $signed(rsp_tdata));
               error_count++;
            end
         end
      end
   end

   // Bound the run; a hung handshake ends here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_fir_convolution_16bit_unit NOT OK");
         $finish;
      end
   end

   // Offer one item from a falling edge, hold it until taken, then update the model.
   // Returns at the falling edge after acceptance with tvalid still high.
   task automatic drive_item(input logic cmd, input logic [TAP_IDX_W-1:0] idx,
                             input logic signed [COEF_W-1:0] coef,
                             input logic signed [SAMPLE_W-1:0] smp);
      while (!burst_mode && $urandom_range(99) < 9) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = {smp, coef, idx};
      do @(negedge clock); while (!req_taken);
      items_sent++;
      if (cmd == CMD_LOAD) begin
         coefs[idx] = coef;
         loads_sent++;
      end else begin
         expected_outputs.push_back(filter_sample(smp));
      end
   endtask

   // Fill the unused fields with junk; the block must ignore them
   task automatic load_coef(input logic [TAP_IDX_W-1:0] idx, input logic signed [COEF_W-1:0] v);
      drive_item(CMD_LOAD, idx, v, SAMPLE_W'($urandom));
   endtask

   task automatic feed_sample(input logic signed [SAMPLE_W-1:0] s);
      drive_item(CMD_SAMPLE, TAP_IDX_W'($urandom), COEF_W'($urandom), s);
   endtask

   // Drop tvalid, wait for every pending output, then let in-flight loads leave the chain
   task automatic wait_for_quiet();
      req_tvalid = 1'b0;
      while (expected_outputs.size() != 0) begin
         @(negedge clock);
      end
      repeat (CHAIN_LATENCY) @(negedge clock);
   endtask

   task automatic set_tap_count(input logic [TAP_COUNT_W-1:0] n);
      wait_for_quiet();
      csr_wr_en   = 1'b1;
      csr_wr_data = n;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      taps_in_use = n;
   endtask

   function automatic logic signed [COEF_W-1:0] random_coef();
      case ($urandom_range(9))
         0:       return $urandom_range(1) ? COEF_MAX : COEF_MIN;
         1:       return COEF_W'($urandom);
         default: return COEF_W'(int'($urandom_range(32768)) - 16384);
      endcase
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(9))
         0:       return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
         1:       return SAMPLE_W'(int'($urandom_range(128)) - 64);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // All coefficients clear after reset: every output is zero at the reset tap count
   task automatic test_reset_state();
      feed_sample(SAMPLE_MIN);
      feed_sample(SAMPLE_MAX);
      feed_sample('0);
   endtask

   // Extreme products saturate both ways; small negative products truncate to zero
   task automatic test_saturation_and_truncation();
      load_coef(TAP_IDX_W'(0), COEF_MIN);
      load_coef(TAP_IDX_W'(1), COEF_MAX);
      load_coef(TAP_IDX_W'(2), COEF_W'(3));
      load_coef(TAP_IDX_W'(MAX_TAPS - 1), COEF_W'(-1));
      feed_sample(SAMPLE_MIN);
      feed_sample(SAMPLE_MAX);
      feed_sample(SAMPLE_W'(1));
      feed_sample(SAMPLE_W'(-1));
      feed_sample(SAMPLE_MIN);
   endtask

   // Zero taps gives zero but still shifts; counts above the table size clamp to it
   task automatic test_tap_count_limits();
      set_tap_count('0);
      feed_sample(SAMPLE_MAX);
      feed_sample(SAMPLE_MIN);
      set_tap_count(TAP_COUNT_W'(1));
      feed_sample(SAMPLE_W'(-1));
      feed_sample(SAMPLE_MIN);
      set_tap_count('1);
      feed_sample(SAMPLE_MAX);
      feed_sample(SAMPLE_W'(5));
      set_tap_count(TAP_COUNT_W'(MAX_TAPS + 1));
      feed_sample(SAMPLE_MIN);
   endtask

   // Phases of: tap count write, a coefficient set for the active taps, then a sample
   // stream with occasional coefficient rewrites mixed in
   task automatic test_random_streams();
      int unsigned phase_taps [10] = '{64, 1, 127, 2, 40, 65, 0, 17, 63, 64};
      int          active;
      int          n_loads;
      int          phase_items;
      for (int p = 0; p < 10; p++) begin
         set_tap_count(TAP_COUNT_W'(phase_taps[p]));
         // hold one phase with no idling on either side
         burst_mode  = (p == 3);
         active      = (phase_taps[p] > MAX_TAPS) ? MAX_TAPS : phase_taps[p];
         n_loads     = (active == 0) ? 4 : $urandom_range(1, active);
         phase_items = 0;
         for (int k = 0; k < n_loads; k++) begin
            load_coef((active == 0) ? TAP_IDX_W'($urandom) :
                      TAP_IDX_W'($urandom_range(active - 1)), random_coef());
            phase_items++;
         end
         while (phase_items < PHASE_ITEMS) begin
            if ($urandom_range(9) == 0) begin
               load_coef(TAP_IDX_W'($urandom), random_coef());
            end else begin
               feed_sample(random_sample());
            end
            phase_items++;
         end
         burst_mode = 1'b0;
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tuser       = CMD_LOAD;
      req_tdata       = '0;
      rsp_tready      = 1'b0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      burst_mode      = 1'b0;
      items_sent      = 0;
      loads_sent      = 0;
      foreach (history[j]) begin
         history[j] = '0;
         coefs[j]   = '0;
      end
      taps_in_use = TAP_COUNT_RESET;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_saturation_and_truncation();
      test_tap_count_limits();
      test_random_streams();
      wait_for_quiet();

      $display("Sent %0d items (%0d coefficient loads) across tap counts 0 to 127;",
               items_sent, loads_sent);
      $display("checked %0d filtered outputs, %0d failures.", outputs_checked, error_count);
      if (error_count == 0) begin
         $display("tb_fir_convolution_16bit_unit OK");
      end else begin
         $display("tb_fir_convolution_16bit_unit NOT OK");
      end
      $finish;
   end

endmodule
